>>> hdl/led_aspect_fade_sequencer_top_assert.svh
// Assertion macros for the LED aspect fade sequencer.
`ifndef LED_ASPECT_FADE_SEQUENCER_TOP_ASSERT_SVH
`define LED_ASPECT_FADE_SEQUENCER_TOP_ASSERT_SVH

// a property that must hold at every clock edge out of reset
`define LAFS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// an implication from one cycle to the next
`define LAFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lafs_pkg.sv
package lafs_pkg;

	localparam int MAX_LED_COUNT_DEF = 64;
	localparam int STEP_ENTRIES_DEF  = 64;
	localparam int ASPECT_COUNT_DEF  = 16;

	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_SELECT = 2'd1;
	localparam logic [1:0] MODE_STEP   = 2'd2;
	localparam logic [1:0] MODE_MAP    = 2'd3;

	localparam logic [1:0] REG_LEDS_IN_USE = 2'd0;
	localparam logic [1:0] REG_DIV_DOWN    = 2'd1;
	localparam logic [1:0] REG_DIV_UP      = 2'd2;

	localparam logic [6:0] LEDS_IN_USE_RST = 7'd0;
	localparam logic [7:0] DIV_RST         = 8'd4;

	// request to the fade divider
	typedef struct packed {
		logic       start;
		logic [7:0] cur;
		logic [7:0] tgt;
		logic [7:0] div_dn;
		logic [7:0] div_up;
	} fade_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] level;
		logic       more;
	} fade_rsp_t;

endpackage

>>> hdl/lafs_fade.sv
// One fade move: level toward target by diff/divisor, restoring division,
// one quotient bit per cycle.
module lafs_fade (
	input  logic                clk,
	input  logic                arst_n,
	input  lafs_pkg::fade_req_t req,
	output lafs_pkg::fade_rsp_t rsp
);

	logic       busy_q;
	logic [3:0] cnt_q;
	logic       down_q;
	logic       more_q;
	logic [7:0] cur_q;
	logic [7:0] tgt_q;
	logic [7:0] dvs_q;
	logic [7:0] quo_q;
	logic [8:0] rem_q;
	logic [7:0] dvd_q;

	logic [7:0] diff;
	logic [7:0] dvs;
	logic [8:0] rem_sh;
	logic [8:0] rem_sub;
	logic       done;

	always_comb begin
		if (req.cur > req.tgt) begin
			diff = req.cur - req.tgt;
			dvs  = (req.div_dn == 8'd0) ? 8'd1 : req.div_dn;
		end else begin
			diff = req.tgt - req.cur;
			dvs  = (req.div_up == 8'd0) ? 8'd1 : req.div_up;
		end
	end

	assign rem_sh  = {rem_q[7:0], dvd_q[7]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign done    = busy_q && (cnt_q == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd8;
		end else if (busy_q) begin
			if (cnt_q == 4'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cur_q  <= req.cur;
			tgt_q  <= req.tgt;
			down_q <= req.cur > req.tgt;
			dvs_q  <= dvs;
			more_q <= (req.cur != req.tgt) && (diff >= dvs);
			dvd_q  <= diff;
			rem_q  <= 9'd0;
			quo_q  <= 8'd0;
		end else if (busy_q && cnt_q != 4'd0) begin
			dvd_q <= {dvd_q[6:0], 1'b0};
			if (!rem_sub[8]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	always_comb begin
		rsp.done = done;
		rsp.more = more_q;
		if (!more_q) begin
			rsp.level = tgt_q;
		end else if (down_q) begin
			rsp.level = cur_q - quo_q;
		end else begin
			rsp.level = cur_q + quo_q;
		end
	end

endmodule

>>> hdl/led_aspect_fade_sequencer_top.sv
// LED aspect fade sequencer. Commands take start while busy is low. A table write
// completes in its accept cycle and busy stays low. A selection of an in-range LED and
// aspect keeps busy high while it reads the map entry, then the step entry; it fades
// toward the step target if the step period is nonzero, sets the level to the target if
// it is zero, and ends with no result if the mapped first step is out of range; else it
// yields one result. A tick walks LEDs 0..min(leds_in_use, MAX_LED_COUNT)-1 (up to two
// fade moves through the shared serial divider, plus LED and step memory reads), one
// result per LED, last on the final one. Each result appears for one cycle with strobe
// high, the cycle after its LED is written back; the receiver cannot stall results.
// After reset the LED state memory is cleared entry by entry while busy is high.
module led_aspect_fade_sequencer_top #(
	parameter int MAX_LED_COUNT = lafs_pkg::MAX_LED_COUNT_DEF,
	parameter int ASPECT_COUNT  = lafs_pkg::ASPECT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [5:0] led_number,
	input  logic [3:0] aspect,
	input  logic [5:0] entry_index,
	input  logic [7:0] step_period,
	input  logic [7:0] step_target,
	input  logic [7:0] step_increment,
	input  logic [7:0] first_step,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       strobe,
	output logic [5:0] led_out,
	output logic [7:0] level,
	output logic       still_fading,
	output logic       last
);

	// step index wraps by dropping upper bits, so the table size stays fixed
	localparam int STEP_ENTRIES = lafs_pkg::STEP_ENTRIES_DEF;

	localparam int LW = (MAX_LED_COUNT > 1) ? $clog2(MAX_LED_COUNT) : 1;
	localparam int SW = (STEP_ENTRIES > 1) ? $clog2(STEP_ENTRIES) : 1;
	localparam int AW = (ASPECT_COUNT > 1) ? $clog2(ASPECT_COUNT) : 1;

	// per-LED state word
	typedef struct packed {
		logic [7:0] pwm;
		logic [7:0] ticks;
		logic [7:0] period;
		logic [7:0] target;
		logic [7:0] incr;
		logic [7:0] ptr;
		logic       fading;
	} led_word_t;

	typedef enum logic [11:0] {
		ST_CLEAR  = 12'b000000000001,
		ST_IDLE   = 12'b000000000010,
		ST_RD_LED = 12'b000000000100,
		ST_LED    = 12'b000000001000,
		ST_FADE1  = 12'b000000010000,
		ST_ADV    = 12'b000000100000,
		ST_RD_STP = 12'b000001000000,
		ST_LOAD   = 12'b000010000000,
		ST_FADE2  = 12'b000100000000,
		ST_WB     = 12'b001000000000,
		ST_RD_MAP = 12'b010000000000,
		ST_MAP    = 12'b100000000000
	} state_t;

	state_t state_q;

	led_word_t   led_mem [MAX_LED_COUNT];
	logic [23:0] step_mem [STEP_ENTRIES];
	logic [7:0]  map_mem [ASPECT_COUNT];

	logic [6:0] leds_in_use_q;
	logic [7:0] div_dn_q;
	logic [7:0] div_up_q;

	logic [LW-1:0] idx_q;
	logic [8:0]    n_q;
	logic          is_tick_q;
	led_word_t     st_q;
	led_word_t     led_rd_q;
	logic [23:0]   step_rd_q;
	logic [7:0]    map_rd_q;
	logic [LW-1:0] clr_q;

	lafs_pkg::fade_req_t freq;
	lafs_pkg::fade_rsp_t frsp;

	logic          accept;
	logic [8:0]    n_eff;
	logic [LW-1:0] sel_led;
	logic [7:0]    ticks_inc;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign n_eff     = ({2'b0, leds_in_use_q} > 9'(MAX_LED_COUNT)) ? 9'(MAX_LED_COUNT)
		: {2'b0, leds_in_use_q};
	assign sel_led   = LW'(led_number);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leds_in_use_q <= lafs_pkg::LEDS_IN_USE_RST;
			div_dn_q      <= lafs_pkg::DIV_RST;
			div_up_q      <= lafs_pkg::DIV_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lafs_pkg::REG_LEDS_IN_USE: leds_in_use_q <= cfg_data[6:0];
				lafs_pkg::REG_DIV_DOWN:    div_dn_q <= cfg_data;
				lafs_pkg::REG_DIV_UP:      div_up_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lafs_fade u_fade (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (freq),
		.rsp    (frsp)
	);

	// the first move reads the fresh LED word, the second the fresh step entry
	always_comb begin
		freq.start  = (state_q == ST_LED && led_rd_q.fading) || (state_q == ST_LOAD
			&& (is_tick_q || step_rd_q[23:16] != 8'd0));
		freq.cur    = (state_q == ST_LED) ? led_rd_q.pwm : st_q.pwm;
		if (state_q == ST_LED) begin
			freq.tgt = led_rd_q.target;
		end else if (state_q == ST_LOAD) begin
			freq.tgt = step_rd_q[15:8];
		end else begin
			freq.tgt = st_q.target;
		end
		freq.div_dn = div_dn_q;
		freq.div_up = div_up_q;
	end

	assign ticks_inc = (st_q.ticks == 8'hFF) ? 8'hFF : st_q.ticks + 8'd1;

	// table and LED memories, registered reads
	always_ff @(posedge clk) begin
		if (accept && mode == lafs_pkg::MODE_STEP && 32'(entry_index) < STEP_ENTRIES) begin
			step_mem[SW'(entry_index)] <= {step_period, step_target, step_increment};
		end
		if (accept && mode == lafs_pkg::MODE_MAP && 32'(aspect) < ASPECT_COUNT) begin
			map_mem[AW'(aspect)] <= first_step;
		end
		step_rd_q <= step_mem[SW'(st_q.ptr)];
		// map entry is captured with the command and held while busy
		if (state_q == ST_IDLE) map_rd_q <= map_mem[AW'(aspect)];
		led_rd_q  <= led_mem[idx_q];
		if (state_q == ST_CLEAR) begin
			led_mem[clr_q] <= '0;
		end else if (state_q == ST_WB) begin
			led_mem[idx_q] <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LW'(1);
					if (32'(clr_q) == MAX_LED_COUNT - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (mode == lafs_pkg::MODE_TICK && n_eff != 9'd0) begin
							state_q <= ST_RD_LED;
						end else if (mode == lafs_pkg::MODE_SELECT
							&& {3'b0, led_number} < n_eff && 32'(aspect) < ASPECT_COUNT) begin
							state_q <= ST_RD_MAP;
						end
					end
				end
				ST_RD_MAP: state_q <= ST_MAP;
				ST_MAP: state_q <= (32'(map_rd_q) < STEP_ENTRIES) ? ST_RD_STP : ST_IDLE;
				ST_RD_LED: state_q <= ST_LED;
				ST_LED: state_q <= led_rd_q.fading ? ST_FADE1 : ST_ADV;
				ST_FADE1: if (frsp.done) state_q <= ST_ADV;
				ST_ADV: state_q <= (ticks_inc >= st_q.period && st_q.incr != 8'd0)
					? ST_RD_STP : ST_WB;
				ST_RD_STP: state_q <= ST_LOAD;
				ST_LOAD: state_q <= (is_tick_q || step_rd_q[23:16] != 8'd0)
					? ST_FADE2 : ST_WB;
				ST_FADE2: if (frsp.done) state_q <= ST_WB;
				ST_WB: begin
					strobe <= 1'b1;
					if (is_tick_q && 9'(idx_q) + 9'd1 < n_q) begin
						state_q <= ST_RD_LED;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath; the LED word is a registered read, landing the cycle after its address is set
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				is_tick_q <= (mode == lafs_pkg::MODE_TICK);
				n_q       <= n_eff;
				idx_q     <= (mode == lafs_pkg::MODE_TICK) ? '0 : sel_led;
			end
			ST_RD_LED: ;
			ST_RD_MAP: ;
			ST_MAP: st_q <= led_rd_q;
			ST_LED: st_q <= led_rd_q;
			ST_FADE1: if (frsp.done) begin
				st_q.pwm    <= frsp.level;
				st_q.fading <= frsp.more;
			end
			ST_ADV: begin
				st_q.ticks <= ticks_inc;
				if (ticks_inc >= st_q.period && st_q.incr != 8'd0) begin
					st_q.ptr <= st_q.ptr + st_q.incr;
				end
			end
			ST_RD_STP: ;
			ST_LOAD: begin
				st_q.ticks  <= 8'd0;
				st_q.period <= step_rd_q[23:16];
				st_q.target <= step_rd_q[15:8];
				st_q.incr   <= step_rd_q[7:0];
				if (!is_tick_q && step_rd_q[23:16] == 8'd0) begin
					st_q.pwm <= step_rd_q[15:8];
				end
			end
			ST_FADE2: if (frsp.done) begin
				st_q.pwm    <= frsp.level;
				st_q.fading <= frsp.more;
			end
			ST_WB: begin
				led_out      <= 6'(idx_q);
				level        <= st_q.pwm;
				still_fading <= st_q.fading;
				last         <= !is_tick_q || (9'(idx_q) + 9'd1 >= n_q);
				if (is_tick_q) idx_q <= idx_q + LW'(1);
			end
			default: ;
		endcase
		// selection: pointer comes from the map
		if (state_q == ST_MAP) st_q.ptr <= map_rd_q;
	end

endmodule

>>> hdl/lafs_checker.sv
`include "led_aspect_fade_sequencer_top_assert.svh"

module lafs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic       last,
	input logic [1:0] mode
);

	logic tbl_wr;

	assign tbl_wr = start && !busy
		&& (mode == lafs_pkg::MODE_STEP || mode == lafs_pkg::MODE_MAP);

	`LAFS_ASSERT(a_strobe_busy, clk, arst_n, !strobe || $past(busy), "result without a busy cycle")
	`LAFS_ASSERT_NEXT(a_last_idle, clk, arst_n, strobe && last, !strobe, "result after last")
	`LAFS_ASSERT_NEXT(a_write_quick, clk, arst_n, tbl_wr, !busy && !strobe, "table write took time")

endmodule

bind led_aspect_fade_sequencer_top lafs_checker u_lafs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.last   (last),
	.mode   (mode)
);
